FILE: rtl/core/spq_pkg.sv
// Package for the stable priority queue.
// Holds the capacity, derived widths, command and status codes, and the control struct.
// No dependencies.
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int CMD_W    = 2;
    localparam int VAL_W    = 32;
    localparam int PRIO_W   = 16;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/spq_if.sv
// Channel interfaces for the stable priority queue: request and response.
// Depends on spq_pkg.
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRIO_W-1:0] priority_req;

    modport source (output valid, command, value, priority_req, input ready);
    modport sink   (input valid, command, value, priority_req, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] head_value;
    logic [STAT_W-1:0]       status;
    logic [COUNT_W-1:0]      entry_count;

    modport source (output valid, head_value, status, entry_count, input ready);
    modport sink   (input valid, head_value, status, entry_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_datapath.
//
// Each item is handled in turn: the command is first taken in, and then in the
// update step all sixteen sorted cells compare against the new priority at once
// and shift to insert or remove; no new item is accepted until that update is
// done. The next item is accepted while the previous result is still waiting at
// the output; the update step holds only while that result has not been taken.
`default_nettype none

module stable_priority_queue
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    t_ctl ctl;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_ctl       (ctl)
    );

    spq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_command      (i_req.command),
        .i_value        (i_req.value),
        .i_priority_req (i_req.priority_req),
        .o_head_value   (o_rsp.head_value),
        .o_status       (o_rsp.status),
        .o_entry_count  (o_rsp.entry_count)
    );

endmodule

`default_nettype wire

FILE: rtl/core/spq_datapath.sv
// Datapath of the stable priority queue: sorted entry cells, occupancy and result register.
// Depends on spq_pkg.
`default_nettype none

module spq_datapath
    import spq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_ctl                     i_ctl,
    input  wire logic [CMD_W-1:0]         i_command,
    input  wire logic signed [VAL_W-1:0]  i_value,
    input  wire logic signed [PRIO_W-1:0] i_priority_req,
    output logic signed [VAL_W-1:0]       o_head_value,
    output logic [STAT_W-1:0]             o_status,
    output logic [COUNT_W-1:0]            o_entry_count
);

    logic signed [VAL_W-1:0]  r_val [CAPACITY];
    logic signed [PRIO_W-1:0] r_prio [CAPACITY];
    logic signed [VAL_W-1:0]  n_val [CAPACITY];
    logic signed [PRIO_W-1:0] n_prio [CAPACITY];
    logic [CNT_W-1:0]         r_occ, n_occ;

    t_cmd                     r_cmd;
    logic signed [VAL_W-1:0]  r_in_val;
    logic signed [PRIO_W-1:0] r_in_prio;

    logic signed [VAL_W-1:0]  r_head, n_head;
    t_status                  r_status, n_status;
    logic [COUNT_W-1:0]       r_count;

    logic [CAPACITY-1:0]      keep;
    logic                     full, empty;

    assign full  = (r_occ == CNT_W'(CAPACITY));
    assign empty = (r_occ == '0);

    // An entry stays in place when it is held and its priority is not above the new one.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            keep[i] = (CNT_W'(i) < r_occ) && (r_prio[i] <= r_in_prio);
        end
    end

    always_comb begin
        n_occ    = r_occ;
        n_head   = '0;
        n_status = ST_OK;
        for (int i = 0; i < CAPACITY; i++) begin
            n_val[i]  = r_val[i];
            n_prio[i] = r_prio[i];
        end
        unique case (r_cmd)
            CMD_ENQUEUE: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_occ = r_occ + CNT_W'(1);
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!keep[i]) begin
                            if (i == 0) begin
                                n_val[i]  = r_in_val;
                                n_prio[i] = r_in_prio;
                            end else if (keep[(i == 0) ? 0 : i - 1]) begin
                                n_val[i]  = r_in_val;
                                n_prio[i] = r_in_prio;
                            end else begin
                                n_val[i]  = r_val[(i == 0) ? 0 : i - 1];
                                n_prio[i] = r_prio[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                end
            end
            CMD_DEQUEUE, CMD_PEEK: begin
                if (empty) begin
                    n_head   = '1;
                    n_status = ST_EMPTY;
                end else begin
                    n_head = r_val[0];
                    if (r_cmd == CMD_DEQUEUE) begin
                        n_occ = r_occ - CNT_W'(1);
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            n_val[i]  = r_val[i + 1];
                            n_prio[i] = r_prio[i + 1];
                        end
                    end
                end
            end
            CMD_NOP: begin
                n_status = ST_OK;
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_ctl.exec) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd     <= t_cmd'(i_command);
            r_in_val  <= i_value;
            r_in_prio <= i_priority_req;
        end
        if (i_ctl.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_val[i]  <= n_val[i];
                r_prio[i] <= n_prio[i];
            end
            r_head   <= n_head;
            r_status <= n_status;
            r_count  <= COUNT_W'(n_occ);
        end
    end

    assign o_head_value  = r_head;
    assign o_status      = r_status;
    assign o_entry_count = r_count;

endmodule

`default_nettype wire

FILE: rtl/core/spq_ctrl.sv
// Controller of the stable priority queue: capture and update sequencing, result valid.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_ctl      o_ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_ctl.capture = i_in_valid && (r_state == S_IDLE);
    assign o_ctl.exec    = (r_state == S_EXEC) && slot_free;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            priority if ((r_state == S_EXEC) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
// Port-level checks for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue.
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_req_valid,
    input wire logic                    i_req_ready,
    input wire logic                    i_rsp_valid,
    input wire logic                    i_rsp_ready,
    input wire logic signed [VAL_W-1:0] i_head_value,
    input wire logic [STAT_W-1:0]       i_status,
    input wire logic [COUNT_W-1:0]      i_entry_count
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_head_value))
        else $error("Result item changed while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("Item accepted while the previous one is in work.");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_FULL |->
            i_entry_count == COUNT_W'(CAPACITY) && i_head_value == '0)
        else $error("Full status with wrong count or head value.");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_EMPTY |->
            i_entry_count == '0 && i_head_value == -32'sd1)
        else $error("Empty status with wrong count or head value.");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_head_value  (o_rsp.head_value),
    .i_status      (o_rsp.status),
    .i_entry_count (o_rsp.entry_count)
);

`default_nettype wire
